// ===== hw/rtl/sljfr_pkg.sv =====
// ----------------------------------------------------------------------------
// Frame receiver package
// Shared types and constants for the start/length/XOR frame receiver.
// ----------------------------------------------------------------------------
package sljfr_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned KIND_W      = 2;
    localparam int unsigned CFG_INDEX_W = 8;

    localparam logic [BYTE_W-1:0] START_BYTE_RESET = 8'hEF;
    localparam logic [BYTE_W-1:0] MAX_LENGTH_RESET = 8'hFF;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_START_BYTE = 8'd0,
        CFG_MAX_LENGTH = 8'd1
    } t_cfg_index;

    typedef enum logic [1:0] {
        PH_HUNT   = 2'd0,
        PH_LENGTH = 2'd1,
        PH_DATA   = 2'd2,
        PH_CHECK  = 2'd3
    } t_phase;

    typedef enum logic [KIND_W-1:0] {
        KIND_DATA   = 2'd0,
        KIND_GOOD   = 2'd1,
        KIND_BAD    = 2'd2,
        KIND_REJECT = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] value;
        logic [BYTE_W-1:0] position;
    } t_result;

    typedef struct packed {
        logic [BYTE_W-1:0] start_byte;
        logic [BYTE_W-1:0] max_length;
    } t_cfg;

endpackage

// ===== hw/rtl/sljfr_cfg.sv =====
// ----------------------------------------------------------------------------
// Frame receiver configuration registers
// Holds the start byte and the maximum payload length.
// ----------------------------------------------------------------------------
module sljfr_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [sljfr_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [sljfr_pkg::BYTE_W-1:0]        i_cfg_data,
    output sljfr_pkg::t_cfg                     o_cfg
);
    import sljfr_pkg::*;

    logic [BYTE_W-1:0] r_start_byte;
    logic [BYTE_W-1:0] r_max_length;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= START_BYTE_RESET;
            r_max_length <= MAX_LENGTH_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_START_BYTE) begin
                r_start_byte <= i_cfg_data;
            end
            if (i_cfg_index == CFG_MAX_LENGTH) begin
                r_max_length <= i_cfg_data;
            end
        end
    end

    assign o_cfg.start_byte = r_start_byte;
    assign o_cfg.max_length = r_max_length;

endmodule

// ===== hw/rtl/sljfr_core.sv =====
// ----------------------------------------------------------------------------
// Frame receiver core
// Input byte register and the frame phase machine with its counters.
// ----------------------------------------------------------------------------
module sljfr_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  sljfr_pkg::t_cfg                i_cfg,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [sljfr_pkg::BYTE_W-1:0]   i_byte,
    input  logic                           i_res_ready,
    output logic                           o_res_valid,
    output sljfr_pkg::t_result             o_res
);
    import sljfr_pkg::*;

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    t_phase            r_phase;
    t_phase            n_phase;
    logic [BYTE_W-1:0] r_frame_length;
    logic [BYTE_W-1:0] n_frame_length;
    logic [BYTE_W-1:0] r_byte_count;
    logic [BYTE_W-1:0] n_byte_count;
    logic [BYTE_W-1:0] r_running_xor;
    logic [BYTE_W-1:0] n_running_xor;
    logic [BYTE_W-1:0] count_inc;
    logic              step;
    logic              emit;
    t_result           res;

    assign step    = r_in_valid && i_res_ready;
    assign o_ready = !r_in_valid || step;
    assign count_inc = r_byte_count + 8'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_HUNT;
            r_frame_length <= '0;
            r_byte_count   <= '0;
            r_running_xor  <= '0;
        end else if (step) begin
            r_phase        <= n_phase;
            r_frame_length <= n_frame_length;
            r_byte_count   <= n_byte_count;
            r_running_xor  <= n_running_xor;
        end
    end

    always_comb begin
        n_phase        = r_phase;
        n_frame_length = r_frame_length;
        n_byte_count   = r_byte_count;
        n_running_xor  = r_running_xor;
        emit           = 1'b0;
        res.kind       = KIND_DATA;
        res.value      = r_in_byte;
        res.position   = '0;
        case (r_phase)
            PH_HUNT: begin
                if (r_in_byte == i_cfg.start_byte) begin
                    n_phase = PH_LENGTH;
                end
            end
            PH_LENGTH: begin
                if (r_in_byte > i_cfg.max_length) begin
                    n_phase  = PH_HUNT;
                    emit     = 1'b1;
                    res.kind = KIND_REJECT;
                end else begin
                    n_frame_length = r_in_byte;
                    n_byte_count   = '0;
                    n_running_xor  = r_in_byte;
                    n_phase        = (r_in_byte == '0) ? PH_CHECK : PH_DATA;
                end
            end
            PH_DATA: begin
                emit          = 1'b1;
                res.kind      = KIND_DATA;
                res.position  = r_byte_count;
                n_running_xor = r_running_xor ^ r_in_byte;
                n_byte_count  = count_inc;
                if (count_inc == r_frame_length) begin
                    n_phase = PH_CHECK;
                end
            end
            PH_CHECK: begin
                n_phase      = PH_HUNT;
                emit         = 1'b1;
                res.kind     = (r_in_byte == r_running_xor) ? KIND_GOOD : KIND_BAD;
                res.position = r_frame_length;
            end
            default: begin
                n_phase = PH_HUNT;
            end
        endcase
    end

    assign o_res_valid = step && emit;
    assign o_res       = res;

endmodule

// ===== hw/rtl/sljfr_out.sv =====
// ----------------------------------------------------------------------------
// Frame receiver result register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module sljfr_out (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_can_load,
    input  sljfr_pkg::t_result    i_res,
    output logic                  o_valid,
    input  logic                  i_ready,
    output sljfr_pkg::t_result    o_res
);
    import sljfr_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_can_load = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_load && i_valid) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// ===== hw/rtl/sop_length_xor_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// Start/length/XOR frame receiver
// Recovers frames of start byte, length, payload and XOR check byte from a
// byte stream and reports payload bytes and frame results.
// ----------------------------------------------------------------------------
// The receiver takes one byte per cycle while results are taken downstream:
// a byte passes through an input register, the combinational phase and XOR
// logic, and a result register that drives the output.
// Throughput is set by the single result register, which is reloaded in the
// same cycle its content is transferred out. Configuration writes take
// effect at once and are expected only while no frame byte is in flight.
// ----------------------------------------------------------------------------
module sop_length_xor_frame_receiver (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [sljfr_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [sljfr_pkg::BYTE_W-1:0]        i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [sljfr_pkg::BYTE_W-1:0]        i_rx_byte,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [sljfr_pkg::KIND_W-1:0]        o_kind,
    output logic [sljfr_pkg::BYTE_W-1:0]        o_value,
    output logic [sljfr_pkg::BYTE_W-1:0]        o_position
);
    import sljfr_pkg::*;

    t_cfg    cfg;
    logic    res_valid;
    logic    can_load;
    t_result res;
    t_result out_res;

    assign o_cfg_ready = 1'b1;

    sljfr_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    sljfr_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_byte      (i_rx_byte),
        .i_res_ready (can_load),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    sljfr_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (res_valid),
        .o_can_load (can_load),
        .i_res      (res),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_res      (out_res)
    );

    assign o_kind     = out_res.kind;
    assign o_value    = out_res.value;
    assign o_position = out_res.position;

endmodule
